// ===== src/twg_pkg.sv =====
// ----------------------------------------------------------------------------
// twg_pkg
// Shared types, constants and arithmetic helpers for the twiddle generator.
// ----------------------------------------------------------------------------
package twg_pkg;

  // Port widths
  localparam int unsigned INDEX_W    = 15;
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = 5;

  // Configuration register indices
  localparam logic [CFG_INDEX_W-1:0] REG_SIZE_LOG2 = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_INVERSE   = 1'd1;

  localparam logic [CFG_DATA_W-1:0] SIZE_LOG2_RESET = 5'd10;

  // Unsigned Q.62 magnitudes: values reach 2^62, so 63 bits are kept.
  localparam int unsigned QW     = 63;
  localparam int unsigned PROD_W = 2 * QW;

  // pi/4 scaling of the reduced phase into Q.62 radians
  localparam logic [32:0] PI_SCALED = 33'h1921FB544;

  localparam int unsigned SERIES_TERMS = 8;

  typedef logic [QW-1:0] q62_t;

  localparam q62_t ONE_Q62 = q62_t'(1) << 62;

  // Four partial products of a 63 x 63 bit multiplication
  typedef struct packed {
    logic [63:0] ll;
    logic [63:0] lh;
    logic [63:0] hl;
    logic [63:0] hh;
  } pprod_t;

  // Beat travelling down the series pipeline
  typedef struct packed {
    logic       valid;
    logic       flag;
    logic [2:0] oct;
    q62_t       x2;
    q62_t       ts;
    q62_t       tc;
    q62_t       ss;
    q62_t       sc;
  } series_t;

  // First half of a split multiplication: the 32-bit partial products.
  function automatic pprod_t pp_mul(input q62_t a, input q62_t b);
    pprod_t p;
    p.ll = 64'(a[31:0])    * 64'(b[31:0]);
    p.lh = 64'(a[31:0])    * 64'(b[QW-1:32]);
    p.hl = 64'(a[QW-1:32]) * 64'(b[31:0]);
    p.hh = 64'(a[QW-1:32]) * 64'(b[QW-1:32]);
    return p;
  endfunction

  // Second half: weighted sum of the partial products.
  function automatic logic [PROD_W-1:0] pp_sum(input pprod_t p);
    return PROD_W'(p.ll) + (PROD_W'(p.lh) << 32) + (PROD_W'(p.hl) << 32)
           + (PROD_W'(p.hh) << 64);
  endfunction

endpackage

// ===== src/twg_in_if.sv =====
// ----------------------------------------------------------------------------
// twg_in_if
// Index channel of the twiddle generator: valid/ready with the twiddle index.
// ----------------------------------------------------------------------------
interface twg_in_if;
  import twg_pkg::*;

  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] index;

  modport source (output valid, output index, input ready);
  modport sink   (input valid, input index, output ready);
endinterface

// ===== src/twg_out_if.sv =====
// ----------------------------------------------------------------------------
// twg_out_if
// Result channel of the twiddle generator: valid/ready with cos, sin and flag.
// ----------------------------------------------------------------------------
interface twg_out_if #(
  parameter int unsigned OUT_BITS = 16
);
  logic                       valid;
  logic                       ready;
  logic signed [OUT_BITS-1:0] cos_value;
  logic signed [OUT_BITS-1:0] sin_value;
  logic                       index_out_of_range;

  modport source (output valid, output cos_value, output sin_value,
                  output index_out_of_range, input ready);
  modport sink   (input valid, input cos_value, input sin_value,
                  input index_out_of_range, output ready);
endinterface

// ===== src/twg_term.sv =====
// ----------------------------------------------------------------------------
// twg_term
// One Taylor term of the sine and cosine series: four pipeline stages that
// multiply the previous terms by x^2 and divide by the factorial factors
// through a reciprocal multiplication.
// ----------------------------------------------------------------------------
module twg_term #(
  parameter int unsigned K = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  twg_pkg::series_t  s_in,
  output twg_pkg::series_t  s_out
);
  import twg_pkg::*;

  // Divisors of this term and their exact reciprocals.
  // With v < 2^62 and shift 62 + ceil(log2 d), floor(v * m >> shift) = v / d.
  localparam int unsigned D_SIN  = (2 * K) * (2 * K + 1);
  localparam int unsigned D_COS  = (2 * K - 1) * (2 * K);
  localparam int unsigned SH_SIN = 62 + $clog2(D_SIN);
  localparam int unsigned SH_COS = 62 + $clog2(D_COS);
  localparam logic [127:0] M_SIN_W =
    ((128'd1 << SH_SIN) + 128'(D_SIN) - 128'd1) / 128'(D_SIN);
  localparam logic [127:0] M_COS_W =
    ((128'd1 << SH_COS) + 128'(D_COS) - 128'd1) / 128'(D_COS);
  localparam q62_t M_SIN = M_SIN_W[QW-1:0];
  localparam q62_t M_COS = M_COS_W[QW-1:0];

  // The incoming term has index K-1; odd terms are subtracted.
  localparam bit SUB_PREV = ((K - 1) % 2) == 1;

  series_t             side_a_r, side_a_nxt;
  series_t             side_b_r;
  series_t             side_c_r;
  series_t             side_d_r, side_d_nxt;
  pprod_t              pps_a_r, pps_a_nxt, ppc_a_r, ppc_a_nxt;
  q62_t                vs_b_r, vs_b_nxt, vc_b_r, vc_b_nxt;
  pprod_t              pps_c_r, pps_c_nxt, ppc_c_r, ppc_c_nxt;
  logic [PROD_W-1:0]   prod_s_b, prod_c_b, quo_s_d, quo_c_d;

  // Stage a: accumulate the previous term and start term * x^2.
  always_comb begin
    side_a_nxt = s_in;
    if (SUB_PREV) begin
      side_a_nxt.ss = s_in.ss - s_in.ts;
      side_a_nxt.sc = s_in.sc - s_in.tc;
    end else begin
      side_a_nxt.ss = s_in.ss + s_in.ts;
      side_a_nxt.sc = s_in.sc + s_in.tc;
    end
    pps_a_nxt = pp_mul(s_in.ts, s_in.x2);
    ppc_a_nxt = pp_mul(s_in.tc, s_in.x2);
  end

  // Stage b: finish the product and drop the 62 fraction bits.
  always_comb begin
    prod_s_b = pp_sum(pps_a_r);
    prod_c_b = pp_sum(ppc_a_r);
    vs_b_nxt = prod_s_b[124:62];
    vc_b_nxt = prod_c_b[124:62];
  end

  // Stage c: start the reciprocal multiplication.
  always_comb begin
    pps_c_nxt = pp_mul(vs_b_r, M_SIN);
    ppc_c_nxt = pp_mul(vc_b_r, M_COS);
  end

  // Stage d: quotients become the new terms.
  always_comb begin
    quo_s_d       = pp_sum(pps_c_r);
    quo_c_d       = pp_sum(ppc_c_r);
    side_d_nxt    = side_c_r;
    side_d_nxt.ts = QW'(quo_s_d >> SH_SIN);
    side_d_nxt.tc = QW'(quo_c_d >> SH_COS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_a_r.valid <= 1'b0;
      side_b_r.valid <= 1'b0;
      side_c_r.valid <= 1'b0;
      side_d_r.valid <= 1'b0;
    end else if (en) begin
      side_a_r <= side_a_nxt;
      pps_a_r  <= pps_a_nxt;
      ppc_a_r  <= ppc_a_nxt;
      side_b_r <= side_a_r;
      vs_b_r   <= vs_b_nxt;
      vc_b_r   <= vc_b_nxt;
      side_c_r <= side_b_r;
      pps_c_r  <= pps_c_nxt;
      ppc_c_r  <= ppc_c_nxt;
      side_d_r <= side_d_nxt;
    end
  end

  assign s_out = side_d_r;

endmodule

// ===== src/fft_twiddle_generator.sv =====
// ----------------------------------------------------------------------------
// fft_twiddle_generator
// Pipelined FFT twiddle factor generator: cos and sin of +/-2*pi*i/N.
// ----------------------------------------------------------------------------
// The block takes one index beat per clock unless a held result stalls it,
// and returns one twiddle beat per index, in order. The depth is set by the
// seven Taylor terms of the series, each of which costs four stages: a
// 63 x 63 bit product split into 32-bit partial products over two stages,
// then a reciprocal multiplication of the same shape for the factorial
// division. Ahead of them sit five stages of phase reduction, angle scaling
// and x^2, and after them two stages of final accumulation, octant folding
// and rounding. A stalled result beat freezes the whole pipeline, so
// in_ch.ready follows out_ch.ready whenever the output register is full.
// Write size_log2 and inverse only while no beat is in flight.
// ----------------------------------------------------------------------------
module fft_twiddle_generator #(
  parameter int unsigned MAX_SIZE_LOG2 = 16,
  parameter int unsigned OUT_BITS      = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [twg_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [twg_pkg::CFG_DATA_W-1:0]      cfg_data,
  twg_in_if.sink                              in_ch,
  twg_out_if.source                           out_ch
);
  import twg_pkg::*;

  // Phase bits kept: the low 32-PW bits of the 32-bit phase are always zero.
  localparam int unsigned PW   = (MAX_SIZE_LOG2 < 3) ? 3 : MAX_SIZE_LOG2;
  localparam int unsigned GW   = PW - 2;
  localparam int unsigned FRAC = OUT_BITS - 1;

  localparam logic [CFG_DATA_W-1:0] LEN_MAX   = CFG_DATA_W'(MAX_SIZE_LOG2);
  localparam logic [CFG_DATA_W-1:0] LEN_RESET =
    (MAX_SIZE_LOG2 < 10) ? CFG_DATA_W'(MAX_SIZE_LOG2) : SIZE_LOG2_RESET;
  localparam logic [GW-1:0]  F_MASK = GW'((64'd1 << (PW - 3)) - 64'd1);
  localparam logic [GW-1:0]  G_ONE  = GW'(64'd1 << (PW - 3));
  localparam logic [FRAC+1:0] Q_ONE = (FRAC + 2)'(1) << FRAC;
  localparam logic [FRAC+1:0] Q_MAX = Q_ONE - (FRAC + 2)'(1);
  localparam bit LAST_SUB = ((SERIES_TERMS - 1) % 2) == 1;

  // Round a Q.62 magnitude to Q1.FRAC and apply the sign with saturation.
  function automatic logic [OUT_BITS-1:0] quant(input q62_t mag, input logic neg);
    logic [QW:0]     sum;
    logic [FRAC+1:0] q;
    logic [FRAC+1:0] nq;
    sum = {1'b0, mag} + ((QW + 1)'(1) << (61 - FRAC));
    q   = sum[QW:62-FRAC];
    if (neg) begin
      if (q > Q_ONE) begin
        q = Q_ONE;
      end
      nq = '0 - q;
      return nq[OUT_BITS-1:0];
    end
    if (q > Q_MAX) begin
      q = Q_MAX;
    end
    return q[OUT_BITS-1:0];
  endfunction

  logic                   en;
  logic [CFG_DATA_W-1:0]  len_r, len_nxt;
  logic                   inverse_r, inverse_nxt;

  logic                   v1_r;
  logic [PW-1:0]          phase1_r, phase1_nxt;
  logic                   flag1_r, flag1_nxt;
  logic [PW+14:0]         ph_wide;
  logic [CFG_DATA_W-1:0]  sh;

  logic                   v2_r, flag2_r;
  logic [2:0]             oct2_r, oct2_nxt;
  logic [GW-1:0]          g2_r, g2_nxt, f2;

  logic                   v3_r, flag3_r;
  logic [2:0]             oct3_r;
  logic [GW+32:0]         xm;
  q62_t                   x3_r, x3_nxt;

  logic                   v4_r, flag4_r;
  logic [2:0]             oct4_r;
  q62_t                   x4_r;
  pprod_t                 pp4_r, pp4_nxt;

  logic [PROD_W-1:0]      prod5;
  series_t                b0_r, b0_nxt;
  series_t                bnd [SERIES_TERMS];

  logic                   vf_r, flagf_r;
  logic [2:0]             octf_r;
  q62_t                   sf_r, sf_nxt, cf_r, cf_nxt;

  logic                   out_valid_r, oor_r;
  logic [OUT_BITS-1:0]    cos_r, cos_nxt, sin_r, sin_nxt;
  q62_t                   cm, sm;
  logic                   cn, sn;

  // The pipeline moves unless a finished beat is held at the output.
  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  // Configuration: the size is clamped to 1..MAX_SIZE_LOG2 when written.
  always_comb begin
    len_nxt     = len_r;
    inverse_nxt = inverse_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_SIZE_LOG2: begin
          if (cfg_data == '0) begin
            len_nxt = CFG_DATA_W'(1);
          end else if (cfg_data > LEN_MAX) begin
            len_nxt = LEN_MAX;
          end else begin
            len_nxt = cfg_data;
          end
        end
        REG_INVERSE: begin
          inverse_nxt = cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r     <= LEN_RESET;
      inverse_r <= 1'b0;
    end else begin
      len_r     <= len_nxt;
      inverse_r <= inverse_nxt;
    end
  end

  // Stage 1: phase word in turns, optional negation, range flag.
  always_comb begin
    sh         = CFG_DATA_W'(PW) - len_r;
    ph_wide    = (PW + 15)'(in_ch.index) << sh;
    phase1_nxt = ph_wide[PW-1:0];
    if (inverse_r) begin
      phase1_nxt = '0 - ph_wide[PW-1:0];
    end
    flag1_nxt = (in_ch.index >> (len_r - CFG_DATA_W'(1))) != '0;
  end

  // Stage 2: octant and reduced phase, mirrored in odd octants.
  always_comb begin
    oct2_nxt = phase1_r[PW-1:PW-3];
    f2       = phase1_r[GW-1:0] & F_MASK;
    g2_nxt   = phase1_r[PW-3] ? (G_ONE - f2) : f2;
  end

  // Stage 3: reduced angle in Q.62 radians.
  always_comb begin
    xm     = (GW + 33)'(g2_r) * (GW + 33)'(PI_SCALED);
    x3_nxt = QW'(64'(xm) << (32 - PW));
  end

  // Stages 4 and 5: x^2, then the first beat of the series.
  always_comb begin
    pp4_nxt      = pp_mul(x3_r, x3_r);
    prod5        = pp_sum(pp4_r);
    b0_nxt.valid = v4_r;
    b0_nxt.flag  = flag4_r;
    b0_nxt.oct   = oct4_r;
    b0_nxt.x2    = prod5[124:62];
    b0_nxt.ts    = x4_r;
    b0_nxt.tc    = ONE_Q62;
    b0_nxt.ss    = '0;
    b0_nxt.sc    = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r       <= 1'b0;
      v2_r       <= 1'b0;
      v3_r       <= 1'b0;
      v4_r       <= 1'b0;
      b0_r.valid <= 1'b0;
    end else if (en) begin
      v1_r     <= in_ch.valid;
      phase1_r <= phase1_nxt;
      flag1_r  <= flag1_nxt;
      v2_r     <= v1_r;
      flag2_r  <= flag1_r;
      oct2_r   <= oct2_nxt;
      g2_r     <= g2_nxt;
      v3_r     <= v2_r;
      flag3_r  <= flag2_r;
      oct3_r   <= oct2_r;
      x3_r     <= x3_nxt;
      v4_r     <= v3_r;
      flag4_r  <= flag3_r;
      oct4_r   <= oct3_r;
      x4_r     <= x3_r;
      pp4_r    <= pp4_nxt;
      b0_r     <= b0_nxt;
    end
  end

  // Taylor terms one to seven.
  assign bnd[0] = b0_r;

  for (genvar k = 1; k < SERIES_TERMS; k++) begin : g_term
    twg_term #(
      .K (k)
    ) u_term (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .s_in  (bnd[k-1]),
      .s_out (bnd[k])
    );
  end

  // Final stage of the series: accumulate the last term with its sign.
  always_comb begin
    if (LAST_SUB) begin
      sf_nxt = bnd[SERIES_TERMS-1].ss - bnd[SERIES_TERMS-1].ts;
      cf_nxt = bnd[SERIES_TERMS-1].sc - bnd[SERIES_TERMS-1].tc;
    end else begin
      sf_nxt = bnd[SERIES_TERMS-1].ss + bnd[SERIES_TERMS-1].ts;
      cf_nxt = bnd[SERIES_TERMS-1].sc + bnd[SERIES_TERMS-1].tc;
    end
  end

  // Octant folding and rounding into the output register.
  always_comb begin
    cm      = (octf_r[0] ^ octf_r[1]) ? sf_r : cf_r;
    sm      = (octf_r[0] ^ octf_r[1]) ? cf_r : sf_r;
    cn      = octf_r[2] ^ octf_r[1];
    sn      = octf_r[2];
    cos_nxt = quant(cm, cn);
    sin_nxt = quant(sm, sn);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vf_r        <= bnd[SERIES_TERMS-1].valid;
      flagf_r     <= bnd[SERIES_TERMS-1].flag;
      octf_r      <= bnd[SERIES_TERMS-1].oct;
      sf_r        <= sf_nxt;
      cf_r        <= cf_nxt;
      out_valid_r <= vf_r;
      oor_r       <= flagf_r;
      cos_r       <= cos_nxt;
      sin_r       <= sin_nxt;
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.cos_value          = cos_r;
  assign out_ch.sin_value          = sin_r;
  assign out_ch.index_out_of_range = oor_r;

endmodule

// ===== dv/tb_fft_twiddle_generator.sv =====
// ----------------------------------------------------------------------------
// tb_fft_twiddle_generator
// Self-checking testbench for the FFT twiddle factor generator.
// ----------------------------------------------------------------------------
// A driver sends index beats from a queue. A monitor checks each result beat
// against a bit-exact predictor of the fixed-point Taylor-series sin/cos,
// including octant folding, rounding, saturation and the range flag.
// The run steps through several size and direction settings. It also steps
// through phases with sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_fft_twiddle_generator;
  import twg_pkg::*;

  localparam int unsigned OUT_W           = 16;
  localparam int unsigned FRAC_W          = OUT_W - 1;
  localparam int unsigned MAX_LOG2        = 16;
  localparam int unsigned NUM_PHASES      = 8;
  localparam int unsigned ITEMS_PER_PHASE = 100;
  localparam int unsigned SETTLE_CYCLES   = 40;
  localparam int unsigned QUIET_LIMIT     = 5000;
  localparam logic [63:0] PI_Q62_STEP     = 64'h1921FB544;

  typedef struct packed {
    logic signed [OUT_W-1:0] cos_value;
    logic signed [OUT_W-1:0] sin_value;
    logic                    out_of_range;
  } twiddle_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  twg_in_if                     in_ch ();
  twg_out_if #(.OUT_BITS(OUT_W)) out_ch ();

  fft_twiddle_generator #(
    .MAX_SIZE_LOG2 (MAX_LOG2),
    .OUT_BITS      (OUT_W)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Clock generation.
  always #10 clk = ~clk;

  // Local copy of the configuration, as last written.
  logic [CFG_DATA_W-1:0] size_log2_q;
  logic                  inverse_q;

  logic [INDEX_W-1:0] index_queue[$];
  twiddle_t           twiddle_expect[$];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles   = 0;

  // Effective size_log2 after clamping the size register.
  function automatic int unsigned clamped_log2(input logic [CFG_DATA_W-1:0] raw);
    if (raw < 1) return 1;
    if (raw > MAX_LOG2) return MAX_LOG2;
    return 32'(raw);
  endfunction

  // Q.62 product: floor(a * b / 2^62), kept to 64 bits.
  function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return prod[125:62];
  endfunction

  // Round a Q.62 magnitude to the output format, with sign and saturation.
  function automatic logic [OUT_W-1:0] round_to_out(input logic [63:0] mag,
                                                    input logic neg);
    logic [63:0] q;
    q = (mag + (64'd1 << (61 - FRAC_W))) >> (62 - FRAC_W);
    if (neg) begin
      if (q > (64'd1 << FRAC_W)) q = 64'd1 << FRAC_W;
      return OUT_W'(64'd0 - q);
    end
    if (q > (64'd1 << FRAC_W) - 1) q = (64'd1 << FRAC_W) - 1;
    return OUT_W'(q);
  endfunction

  // Expected twiddle for one index under the current configuration.
  function automatic twiddle_t twiddle_of(input logic [INDEX_W-1:0] idx);
    int unsigned eff;
    logic [63:0] wide;
    logic [31:0] phase;
    logic [2:0]  octant;
    logic [63:0] g, x, x2, term_s, term_c, sum_s, sum_c;
    logic        swap, c_neg, s_neg;
    twiddle_t    r;
    eff   = clamped_log2(size_log2_q);
    wide  = 64'(idx) << (32 - eff);
    phase = wide[31:0];
    if (inverse_q) phase = 32'd0 - phase;

    // Reduce to the first octant.
    octant = phase[31:29];
    g      = octant[0] ? (64'd1 << 29) - 64'(phase[28:0]) : 64'(phase[28:0]);
    x      = g * PI_Q62_STEP;
    x2     = qmul(x, x);

    // Taylor series with truncating factorial division at each term.
    term_s = x;
    term_c = 64'd1 << 62;
    sum_s  = term_s;
    sum_c  = term_c;
    for (int k = 1; k < SERIES_TERMS; k++) begin
      term_s = qmul(term_s, x2) / 64'((2 * k) * (2 * k + 1));
      term_c = qmul(term_c, x2) / 64'((2 * k - 1) * (2 * k));
      if (k % 2 == 1) begin
        sum_s = sum_s - term_s;
        sum_c = sum_c - term_c;
      end else begin
        sum_s = sum_s + term_s;
        sum_c = sum_c + term_c;
      end
    end

    // Octant symmetry: swap sin and cos where the octant requires it.
    swap  = octant[0] ^ octant[1];
    c_neg = octant[2] ^ octant[1];
    s_neg = octant[2];
    r.cos_value    = round_to_out(swap ? sum_s : sum_c, c_neg);
    r.sin_value    = round_to_out(swap ? sum_c : sum_s, s_neg);
    r.out_of_range = (32'(idx) >= (32'd1 << (eff - 1)));
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // Register write, one beat on the configuration port.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_SIZE_LOG2) size_log2_q = val;
    else if (idx == REG_INVERSE) inverse_q = val[0];
  endtask

  // Wait for every beat to be sent and answered, then let the pipe settle.
  // The state is sampled on the falling edge, when the driver has settled.
  task automatic wait_drained();
    @(negedge clk);
    while (index_queue.size() != 0 || in_ch.valid || twiddle_expect.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Driver: presents queued indices, with random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        twiddle_expect.push_back(twiddle_of(in_ch.index));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (index_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_ch.valid <= 1'b1;
          in_ch.index <= index_queue.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result beat and stalls at random.
  always @(posedge clk) begin
    twiddle_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (twiddle_expect.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          want = twiddle_expect.pop_front();
          if (out_ch.cos_value !== want.cos_value)
            report_mismatch($sformatf("cos_value got %0d want %0d",
                                      out_ch.cos_value, want.cos_value));
          if (out_ch.sin_value !== want.sin_value)
            report_mismatch($sformatf("sin_value got %0d want %0d",
                                      out_ch.sin_value, want.sin_value));
          if (out_ch.index_out_of_range !== want.out_of_range)
            report_mismatch($sformatf("index_out_of_range got %0b want %0b",
                                      out_ch.index_out_of_range, want.out_of_range));
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: ends the run when no beat moves for too long.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Watchdog: no beat moved for %0d cycles", QUIET_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Stimulus: directed indices first, then random phases over several settings.
  initial begin
    logic [CFG_DATA_W-1:0] phase_size[NUM_PHASES];
    logic                  phase_inv[NUM_PHASES];
    logic [INDEX_W-1:0]    directed[$];
    int unsigned eff;
    int unsigned half;

    phase_size = '{5'd10, 5'd1, 5'd16, 5'd0, 5'd31, 5'd4, 5'd12, 5'd17};
    phase_inv  = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    // Zero, quarter and half turns, the table edge, wrap-around and extremes.
    directed   = '{15'd0, 15'd1, 15'd128, 15'd256,
                   15'd384, 15'd511, 15'd512, 15'd513,
                   15'd640, 15'd768, 15'd896, 15'd1023,
                   15'd1024, 15'd1025, 15'd64, 15'd255,
                   15'd257, 15'h5555, 15'h2AAA, 15'h7FFF};

    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = REG_SIZE_LOG2;
    cfg_data       = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    size_log2_q    = SIZE_LOG2_RESET;
    inverse_q      = 1'b0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        wait_drained();
        write_reg(REG_SIZE_LOG2, phase_size[p]);
        write_reg(REG_INVERSE, CFG_DATA_W'(phase_inv[p]));
      end
      @(negedge clk);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      if (p == 0) begin
        foreach (directed[i]) index_queue.push_back(directed[i]);
      end

      // Mostly in-range indices, the rest anywhere in the field.
      eff  = clamped_log2(size_log2_q);
      half = 1 << (eff - 1);
      if (half > 32768) half = 32768;
      repeat (ITEMS_PER_PHASE) begin
        if ($urandom_range(99) < 75)
          index_queue.push_back(INDEX_W'($urandom_range(half - 1)));
        else
          index_queue.push_back(INDEX_W'($urandom_range(32767)));
      end
    end

    wait_drained();
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
